### sv/rae_pkg.sv
`default_nettype none

package rae_pkg;

  localparam int LEN_W = 7;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        range_start;
    logic [IDX_W-1:0]        range_end;
    logic signed [VAL_W-1:0] increment;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_beat_t;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [IDX_W-1:0]        first;
    logic [IDX_W-1:0]        stop;
    logic signed [VAL_W-1:0] inc;
  } cmd_t;

endpackage

`default_nettype wire

### sv/rae_ram.sv
`default_nettype none

module rae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/rae_front.sv
`default_nettype none

module rae_front
  import rae_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire in_beat_t         in_data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  input  wire logic             hold_i,
  output logic      [LEN_W-1:0] len_o,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o,
  input  wire logic             cmd_pop_i
);

  localparam int LEN_CAP = (MAX_LENGTH < 127) ? MAX_LENGTH : 127;

  logic [LEN_W-1:0] cfg_len_q;
  logic [LEN_W-1:0] len_nz;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_m1;

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  logic       accept;
  logic       drop;
  logic       enq;
  logic       deq;
  cmd_t       cmd_new;

  // effective length, clamped to 1..cap
  always_comb begin
    len_nz  = (cfg_len_q == '0) ? LEN_W'(1) : cfg_len_q;
    len_eff = (len_nz > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_nz;
    len_m1  = len_eff - LEN_W'(1);
  end

  assign len_o = len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LEN_W'(64);
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  // classify: empty ranges and ranges past the length are dropped here
  always_comb begin
    cmd_new.kind  = cmd_kind_e'(in_data_i.func);
    cmd_new.first = in_data_i.range_start;
    cmd_new.stop  = ({1'b0, in_data_i.range_end} > len_m1) ? IDX_W'(len_m1)
                                                          : in_data_i.range_end;
    cmd_new.inc   = in_data_i.increment;
    drop = (cmd_new.kind == CMD_ADD) &&
           ((in_data_i.range_start > in_data_i.range_end) ||
            ({1'b0, in_data_i.range_start} >= len_eff));
  end

  assign full        = (cnt_q == 2'd2) || hold_i;
  assign accept      = push && !full;
  assign enq         = accept && !drop;
  assign deq         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

### sv/rae_back.sv
`default_nettype none

module rae_back
  import rae_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [LEN_W-1:0] len_i,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  output logic                  clearing_o,
  output logic                  empty,
  input  wire logic             pop,
  output out_beat_t             out_data_o
);

  localparam int AW       = $clog2(MAX_LENGTH);
  localparam int CW       = (AW > LEN_W) ? AW : LEN_W;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [AW-1:0]           end_q, end_d;
  logic signed [VAL_W-1:0] inc_q, inc_d;
  logic [LEN_W-1:0]        hw_q, hw_d;

  logic                    wb_valid_q, wb_valid_d;
  logic                    wb_add_q, wb_add_d;
  logic                    wb_out_q, wb_out_d;
  logic [AW-1:0]           wb_addr_q;
  logic [IDX_W-1:0]        wb_idx_q, wb_idx_d;
  logic                    wb_last_q, wb_last_d;

  out_beat_t               oq_q [OQ_DEPTH];
  logic [OQ_AW-1:0]        oq_wr_q, oq_rd_q;
  logic [OQ_CW-1:0]        oq_cnt_q;

  logic                    issue;
  logic                    at_end;
  logic                    emit_keep, emit_last;
  logic [CW-1:0]           ptr_cw, len_cw;
  logic [LEN_W-1:0]        stop_p1, hw_max, sweep_len;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;
  logic signed [VAL_W:0]   sum_w;
  logic signed [VAL_W-1:0] sat_w;

  logic                    oq_push, oq_pop;
  out_beat_t               oq_new;

  rae_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_LENGTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ptr_cw    = CW'(ptr_q);
    len_cw    = CW'(len_i);
    emit_keep = ptr_cw < len_cw;
    emit_last = ptr_cw == (len_cw - CW'(1));
    at_end    = ptr_q == end_q;
    issue     = (state_q == ST_ADD) ||
                ((state_q == ST_EMIT) &&
                 ((oq_cnt_q + OQ_CW'(wb_out_q)) < OQ_CW'(OQ_DEPTH)));
    stop_p1   = {1'b0, cmd_i.stop} + LEN_W'(1);
    hw_max    = (stop_p1 > hw_q) ? stop_p1 : hw_q;
    sweep_len = (hw_q > len_i) ? hw_q : len_i;
  end

  // saturating add in the write-back stage
  always_comb begin
    sum_w = {ram_rdata[VAL_W-1], ram_rdata} + {inc_q[VAL_W-1], inc_q};
    if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
      sat_w = sum_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_w = sum_w[VAL_W-1:0];
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = wb_valid_q;
      ram_waddr = wb_addr_q;
      ram_wdata = wb_add_q ? sat_w : '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    end_d      = end_q;
    inc_d      = inc_q;
    hw_d       = hw_q;
    wb_valid_d = 1'b0;
    wb_add_d   = wb_add_q;
    wb_out_d   = 1'b0;
    wb_idx_d   = IDX_W'(ptr_q);
    wb_last_d  = emit_last;
    cmd_pop_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == AW'(MAX_LENGTH - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          inc_d     = cmd_i.inc;
          if (cmd_i.kind == CMD_ADD) begin
            ptr_d   = AW'(cmd_i.first);
            end_d   = AW'(cmd_i.stop);
            hw_d    = hw_max;
            state_d = ST_ADD;
          end else begin
            ptr_d   = '0;
            end_d   = AW'(sweep_len - LEN_W'(1));
            hw_d    = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_ADD, ST_EMIT: begin
        if (issue) begin
          wb_valid_d = 1'b1;
          wb_add_d   = (state_q == ST_ADD);
          wb_out_d   = (state_q == ST_EMIT) && emit_keep;
          ptr_d      = ptr_q + AW'(1);
          if (at_end) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ptr_q      <= '0;
      hw_q       <= '0;
      wb_valid_q <= 1'b0;
      wb_out_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      hw_q       <= hw_d;
      wb_valid_q <= wb_valid_d;
      wb_out_q   <= wb_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q     <= end_d;
    inc_q     <= inc_d;
    wb_add_q  <= wb_add_d;
    wb_addr_q <= ptr_q;
    wb_idx_q  <= wb_idx_d;
    wb_last_q <= wb_last_d;
  end

  // result queue
  assign oq_push            = wb_valid_q && wb_out_q;
  assign oq_pop             = pop && !empty;
  assign oq_new.entry_index = wb_idx_q;
  assign oq_new.entry_value = ram_rdata;
  assign oq_new.last        = wb_last_q;
  assign empty              = (oq_cnt_q == '0);
  assign out_data_o         = oq_q[oq_rd_q];
  assign clearing_o         = (state_q == ST_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OQ_AW'(1);
      end
      oq_cnt_q <= oq_cnt_q + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_new;
    end
  end

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> (oq_cnt_q < OQ_CW'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_clear_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !wb_valid_q)
    else $error("write-back pending during clearing pass");

  a_emit_hw_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (hw_q == '0))
    else $error("high-water mark not reset by emit");

  a_drain_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_IDLE) && !wb_valid_q)
    else $error("drain did not settle");
`endif

endmodule

`default_nettype wire

### sv/range_add_array_engine.sv
// channel  | beat        | handshake             | direction
// ---------+-------------+-----------------------+----------
// input    | in_data_i   | push / full           | in
// result   | out_data_o  | pop / empty           | out
// config   | cfg_wdata_i | cfg_we_i              | in
//
// add beat: read-modify-write of each entry from start to stop, stop clamped to length - 1
// emit beat: sweeps max(length, highest entry added + 1) entries, longer if pop stalls
// a beat that adds nothing is dropped on entry and takes no back-end time
// after reset every entry of the store is cleared, full stays high meanwhile
// a 2-deep command queue and a 4-deep result queue let either side stall alone
`default_nettype none

module range_add_array_engine
  import rae_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire in_beat_t         in_data_i,
  output logic                  empty,
  input  wire logic             pop,
  output out_beat_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i
);

  logic [LEN_W-1:0] len;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             clearing;

  rae_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hold_i      (clearing),
    .len_o       (len),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rae_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### sim/rae_sum_check.sv
`timescale 1ns / 100ps

module rae_sum_check
  import rae_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire logic             full,
  input  wire in_beat_t         in_data_i,
  input  wire logic             empty,
  input  wire logic             pop,
  input  wire out_beat_t        out_data_i,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    beats_due_o
);

  localparam int     DEPTH  = 64;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483647 - 64'sd1;

  logic signed [VAL_W-1:0] sums [DEPTH];
  logic [LEN_W-1:0]        len_reg;
  out_beat_t               beats_due [$];

  initial begin
    fail_count_o = 0;
    beats_due_o  = 0;
  end

  function automatic int used_len(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > DEPTH) return DEPTH;
    return int'(l);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    int        n;
    int        s;
    int        e;
    longint    t;
    if (!rst_ni) begin
      foreach (sums[i]) sums[i] = '0;
      len_reg = LEN_W'(DEPTH);
      beats_due.delete();
      beats_due_o <= 0;
    end else begin
      if (cfg_we_i) len_reg = cfg_wdata_i;

      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          $error("result beat with none expected: index %0d value %0d last %0b",
                 out_data_i.entry_index, out_data_i.entry_value, out_data_i.last);
          fail_count_o++;
        end else begin
          want = beats_due.pop_front();
          if (out_data_i.entry_index !== want.entry_index) begin
            $error("entry_index mismatch: expected %0d, actual %0d",
                   want.entry_index, out_data_i.entry_index);
            fail_count_o++;
          end
          if (out_data_i.entry_value !== want.entry_value) begin
            $error("entry_value mismatch: expected %0d, actual %0d",
                   want.entry_value, out_data_i.entry_value);
            fail_count_o++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_data_i.last);
            fail_count_o++;
          end
        end
      end

      if (push && !full) begin
        n = used_len(len_reg);
        if (in_data_i.func == CMD_EMIT) begin
          for (int i = 0; i < n; i++) begin
            want.entry_index = IDX_W'(i);
            want.entry_value = sums[i];
            want.last        = (i == n - 1);
            beats_due.push_back(want);
          end
          foreach (sums[i]) sums[i] = '0;
        end else begin
          s = int'(in_data_i.range_start);
          e = int'(in_data_i.range_end);
          for (int i = s; i <= e && i < n; i++) begin
            t = longint'(sums[i]) + longint'(in_data_i.increment);
            if (t > SUM_HI) t = SUM_HI;
            if (t < SUM_LO) t = SUM_LO;
            sums[i] = t[VAL_W-1:0];
          end
        end
      end

      beats_due_o <= beats_due.size();
    end
  end

endmodule

### sim/tb_range_add_array_engine.sv
`timescale 1ns / 100ps

module tb_range_add_array_engine;
  import rae_pkg::*;

  localparam int HOLD_OFF = 300;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  logic             pop         = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;
  in_beat_t         in_data_i   = '0;
  logic             full;
  logic             empty;
  out_beat_t        out_data_o;

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int fail_count;
  int beats_due;

  range_add_array_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rae_sum_check sum_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data_i),
    .empty        (empty),
    .pop          (pop),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .beats_due_o  (beats_due)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= take_idle_pct);
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_beat(input in_beat_t b);
    push      <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (full);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic add_range(input int s, input int e, input logic signed [VAL_W-1:0] inc);
    send_beat('{CMD_ADD, IDX_W'(s), IDX_W'(e), inc});
  endtask

  task automatic emit_all();
    send_beat('{CMD_EMIT, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom)});
  endtask

  // stop sending until every result beat is out, then let queued adds finish
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_beat();
    int r;
    int s;
    int e;
    logic signed [VAL_W-1:0] inc;
    r = $urandom_range(99);
    if (r < 15) begin
      emit_all();
    end else begin
      s = $urandom_range(63);
      if (r < 30) e = $urandom_range(63);
      else if (r < 40) e = 63;
      else e = s + $urandom_range(0, (63 - s) < 8 ? (63 - s) : 8);
      case ($urandom_range(9))
        0: inc = 32'sh7FFF_FFFF;
        1: inc = 32'sh8000_0000;
        2, 3, 4, 5: inc = VAL_W'($urandom);
        default: inc = VAL_W'($urandom_range(2000)) - 32'sd1000;
      endcase
      add_range(s, e, inc);
    end
  endtask

  initial begin
    send_idle_pct = 7;
    take_idle_pct = 84;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fresh store, then saturation and empty ranges at the reset length
    emit_all();
    add_range(0, 63, 32'sh7FFF_FFFF);
    add_range(0, 63, 32'sd1);
    add_range(10, 5, 32'sd5);
    add_range(63, 63, -32'sd1);
    add_range(20, 40, 32'sh8000_0000);
    add_range(30, 30, 32'sh8000_0000);
    emit_all();

    // single entry, adds past the end are clipped or dropped
    set_length(7'd1);
    add_range(0, 63, 32'sd7);
    add_range(1, 1, 32'sd3);
    emit_all();

    // zero acts as one
    set_length(7'd0);
    add_range(0, 0, -32'sd9);
    emit_all();

    // above the maximum acts as the maximum
    set_length(7'd127);
    add_range(60, 63, 32'sh8000_0000);
    add_range(0, 0, 32'sh8000_0000);
    emit_all();

    // sums beyond a shortened length are cleared by the emit
    set_length(7'd64);
    add_range(50, 63, 32'sd5);
    set_length(7'd10);
    emit_all();
    set_length(7'd64);
    emit_all();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_length(LEN_W'($urandom_range(1, 64)));
        1: set_length(7'd64);
        default: set_length(LEN_W'($urandom_range(0, 127)));
      endcase
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 84 : 0;
      take_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 7 : 0;
      repeat (50) random_beat();
      emit_all();
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
